[rtl/ffca_pkg.sv]
`default_nettype none
package ffca_pkg;

  localparam int MEM_CELLS_DEF  = 512;
  localparam int MAX_OWNERS_DEF = 32;

  // Port field widths.
  localparam int SIZE_W  = 10;
  localparam int TAG_W   = 5;
  localparam int CELL_W  = 9;
  localparam int STAT_W  = 2;

  // Commands.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOOWNER = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd3;

  // Requests from the controller to the cell map.
  typedef struct packed {
    logic scan_go;
    logic fill_go;
  } map_req_t;

  // Status from the cell map back to the controller.
  typedef struct packed {
    logic idle;
    logic done;
    logic found;
  } map_rsp_t;

endpackage
`default_nettype wire

[rtl/ffca_cell_map.sv]
`default_nettype none
module ffca_cell_map #(
  parameter int MEM_CELLS  = ffca_pkg::MEM_CELLS_DEF,
  parameter int MAX_OWNERS = ffca_pkg::MAX_OWNERS_DEF,
  localparam int CW = $clog2(MEM_CELLS),
  localparam int SW = CW + 1,
  localparam int OW = $clog2(MAX_OWNERS)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ffca_pkg::map_req_t req,
  input  wire logic [SW-1:0]      size,
  input  wire logic [CW-1:0]      fill_first,
  input  wire logic [CW-1:0]      fill_last,
  input  wire logic [OW-1:0]      fill_val,
  output ffca_pkg::map_rsp_t      rsp,
  output logic [CW-1:0]           run_first,
  output logic [CW-1:0]           run_last
);

  localparam logic [1:0] M_CLEAR = 2'd0;
  localparam logic [1:0] M_IDLE  = 2'd1;
  localparam logic [1:0] M_SCAN  = 2'd2;
  localparam logic [1:0] M_FILL  = 2'd3;

  localparam logic [CW-1:0] LAST = CW'(MEM_CELLS - 1);

  logic [OW-1:0] cell_mem [MEM_CELLS];

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] issue_r, issue_nxt;
  logic [CW-1:0] flast_r, flast_nxt;
  logic [OW-1:0] fval_r, fval_nxt;
  logic [SW-1:0] run_r, run_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [CW-1:0] rd_addr_r;
  logic [OW-1:0] rdata_r;
  logic          done_r, done_nxt;
  logic          found_r, found_nxt;
  logic [CW-1:0] first_r, first_nxt;
  logic [CW-1:0] last_r, last_nxt;

  logic          we;
  logic [CW-1:0] waddr;
  logic [OW-1:0] wdata;
  logic [SW-1:0] run_inc;
  logic [SW-1:0] first_calc;

  always_ff @(posedge clk) begin
    if (we) begin
      cell_mem[waddr] <= wdata;
    end
    rdata_r   <= cell_mem[issue_r];
    rd_addr_r <= issue_r;
  end

  assign run_inc    = (rdata_r == '0) ? run_r + SW'(1) : '0;
  assign first_calc = SW'(rd_addr_r) + SW'(1) - size;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    issue_nxt  = issue_r;
    flast_nxt  = flast_r;
    fval_nxt   = fval_r;
    run_nxt    = run_r;
    rd_vld_nxt = 1'b0;
    done_nxt   = 1'b0;
    found_nxt  = found_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    we         = 1'b0;
    waddr      = cnt_r;
    wdata      = fval_r;
    unique case (state_r)
      M_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == LAST) begin
          state_nxt = M_IDLE;
        end
      end
      M_IDLE: begin
        if (req.scan_go) begin
          state_nxt = M_SCAN;
          issue_nxt = '0;
          run_nxt   = '0;
        end else if (req.fill_go) begin
          state_nxt = M_FILL;
          cnt_nxt   = fill_first;
          flast_nxt = fill_last;
          fval_nxt  = fill_val;
        end
      end
      M_SCAN: begin
        rd_vld_nxt = 1'b1;
        if (issue_r != LAST) begin
          issue_nxt = issue_r + CW'(1);
        end
        if (rd_vld_r) begin
          run_nxt = run_inc;
          if (run_inc == size) begin
            state_nxt  = M_IDLE;
            rd_vld_nxt = 1'b0;
            done_nxt   = 1'b1;
            found_nxt  = 1'b1;
            first_nxt  = first_calc[CW-1:0];
            last_nxt   = rd_addr_r;
          end else if (rd_addr_r == LAST) begin
            state_nxt  = M_IDLE;
            rd_vld_nxt = 1'b0;
            done_nxt   = 1'b1;
            found_nxt  = 1'b0;
          end
        end
      end
      M_FILL: begin
        we      = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == flast_r) begin
          state_nxt = M_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= M_CLEAR;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= rd_vld_nxt;
      done_r   <= done_nxt;
    end
    issue_r <= issue_nxt;
    flast_r <= flast_nxt;
    fval_r  <= fval_nxt;
    run_r   <= run_nxt;
    found_r <= found_nxt;
    first_r <= first_nxt;
    last_r  <= last_nxt;
  end

  assign rsp.idle   = (state_r == M_IDLE);
  assign rsp.done   = done_r;
  assign rsp.found  = found_r;
  assign run_first  = first_r;
  assign run_last   = last_r;

endmodule
`default_nettype wire

[rtl/first_fit_cell_allocator_core.sv]
// Allocate: the cell map is scanned from cell 0 up to the last cell of the chosen run, and
// the run is then written with the new owner number.
// A refused allocate answers either without a scan or after the whole map is scanned in vain.
// Free: the freed region is written back to zero; an unknown owner is answered without a fill.
// The cell map memory is read or written one cell a cycle; one item at a time.
// After reset a clearing pass frees every cell while in_ready stays low.
`default_nettype none
module first_fit_cell_allocator_core #(
  parameter int MEM_CELLS  = ffca_pkg::MEM_CELLS_DEF,
  parameter int MAX_OWNERS = ffca_pkg::MAX_OWNERS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_command,
  input  wire logic [ffca_pkg::SIZE_W-1:0]   in_block_size,
  input  wire logic [ffca_pkg::TAG_W-1:0]    in_owner_tag,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ffca_pkg::STAT_W-1:0]        out_status,
  output logic [ffca_pkg::TAG_W-1:0]         out_owner_out,
  output logic [ffca_pkg::CELL_W-1:0]        out_start_cell,
  output logic [ffca_pkg::CELL_W-1:0]        out_end_cell
);

  localparam int CW = $clog2(MEM_CELLS);
  localparam int SW = CW + 1;
  localparam int OW = $clog2(MAX_OWNERS);
  localparam int NW = OW + 1;

  // Controller states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RTAB = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  // Region table: first and last cell per owner. Entries are only read for a live
  // owner, so the table needs no reset; live bits sit in flip-flops.
  logic [2*CW-1:0] region_mem [MAX_OWNERS];
  logic [2*CW-1:0] rtab_rdata_r;
  logic            rtab_we;
  logic [OW-1:0]   rtab_waddr;
  logic [OW-1:0]   rtab_raddr;

  logic [2:0]      state_r, state_nxt;
  logic [NW-1:0]   next_owner_r, next_owner_nxt;
  logic [MAX_OWNERS-1:0] live_r, live_nxt;
  logic [SW-1:0]   size_r, size_nxt;
  logic [OW-1:0]   tag_r, tag_nxt;

  // Pending result, held until the output register can take it.
  logic [ffca_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic [OW-1:0]   res_owner_r, res_owner_nxt;
  logic [CW-1:0]   res_first_r, res_first_nxt;
  logic [CW-1:0]   res_last_r, res_last_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [ffca_pkg::STAT_W-1:0] out_status_r;
  logic [ffca_pkg::TAG_W-1:0]  out_owner_r;
  logic [ffca_pkg::CELL_W-1:0] out_start_r;
  logic [ffca_pkg::CELL_W-1:0] out_end_r;
  logic            out_load;

  ffca_pkg::map_req_t map_req;
  ffca_pkg::map_rsp_t map_rsp;
  logic [CW-1:0]   fill_first, fill_last;
  logic [OW-1:0]   fill_val;
  logic [CW-1:0]   run_first, run_last;

  logic            in_xfer;
  logic            tag_ok;
  logic [OW-1:0]   in_tag_idx;
  logic [OW-1:0]   own_idx;

  assign in_ready   = (state_r == S_IDLE) && map_rsp.idle;
  assign in_xfer    = in_valid && in_ready;
  assign in_tag_idx = OW'(in_owner_tag);
  assign own_idx    = next_owner_r[OW-1:0];
  assign rtab_raddr = in_tag_idx;

  // A free names a known owner only when it is nonzero, in range and still live.
  assign tag_ok = (in_owner_tag != '0) &&
                  (32'(in_owner_tag) < 32'(MAX_OWNERS)) &&
                  live_r[in_tag_idx];

  always_ff @(posedge clk) begin
    if (rtab_we) begin
      region_mem[rtab_waddr] <= {run_first, run_last};
    end
    rtab_rdata_r <= region_mem[rtab_raddr];
  end

  ffca_cell_map #(
    .MEM_CELLS  (MEM_CELLS),
    .MAX_OWNERS (MAX_OWNERS)
  ) u_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (map_req),
    .size       (size_r),
    .fill_first (fill_first),
    .fill_last  (fill_last),
    .fill_val   (fill_val),
    .rsp        (map_rsp),
    .run_first  (run_first),
    .run_last   (run_last)
  );

  // The output register is free when empty or being drained in this cycle.
  assign out_load = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    next_owner_nxt = next_owner_r;
    live_nxt       = live_r;
    size_nxt       = size_r;
    tag_nxt        = tag_r;
    res_status_nxt = res_status_r;
    res_owner_nxt  = res_owner_r;
    res_first_nxt  = res_first_r;
    res_last_nxt   = res_last_r;
    map_req        = '0;
    fill_first     = run_first;
    fill_last      = run_last;
    fill_val       = own_idx;
    rtab_we        = 1'b0;
    rtab_waddr     = own_idx;
    out_valid_nxt  = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          size_nxt       = SW'(in_block_size);
          tag_nxt        = in_tag_idx;
          res_status_nxt = ffca_pkg::ST_DONE;
          res_owner_nxt  = '0;
          res_first_nxt  = '0;
          res_last_nxt   = '0;
          if (in_command == ffca_pkg::CMD_ALLOC) begin
            // Owner exhaustion is checked before the size.
            if (next_owner_r >= NW'(MAX_OWNERS)) begin
              res_status_nxt = ffca_pkg::ST_NOOWNER;
              state_nxt      = S_RESP;
            end else if ((in_block_size == '0) ||
                         (32'(in_block_size) > 32'(MEM_CELLS))) begin
              res_status_nxt = ffca_pkg::ST_NOFIT;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            if (tag_ok) begin
              // The region table read issued this cycle returns in S_RTAB.
              live_nxt[in_tag_idx] = 1'b0;
              state_nxt            = S_RTAB;
            end else begin
              res_status_nxt = ffca_pkg::ST_UNKNOWN;
              state_nxt      = S_RESP;
            end
          end
        end
      end
      S_SCAN: begin
        // The scan request goes out once, on the first cycle the map is idle.
        map_req.scan_go = map_rsp.idle && !map_rsp.done;
        if (map_rsp.done) begin
          if (map_rsp.found) begin
            map_req.fill_go       = 1'b1;
            rtab_we               = 1'b1;
            live_nxt[own_idx]     = 1'b1;
            next_owner_nxt        = next_owner_r + NW'(1);
            res_owner_nxt         = own_idx;
            res_first_nxt         = run_first;
            res_last_nxt          = run_last;
            state_nxt             = S_FILL;
          end else begin
            res_status_nxt = ffca_pkg::ST_NOFIT;
            state_nxt      = S_RESP;
          end
        end
      end
      S_RTAB: begin
        fill_first      = rtab_rdata_r[2*CW-1:CW];
        fill_last       = rtab_rdata_r[CW-1:0];
        fill_val        = '0;
        map_req.fill_go = 1'b1;
        res_owner_nxt   = tag_r;
        res_first_nxt   = rtab_rdata_r[2*CW-1:CW];
        res_last_nxt    = rtab_rdata_r[CW-1:0];
        state_nxt       = S_FILL;
      end
      S_FILL: begin
        if (map_rsp.done) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      next_owner_r <= NW'(1);
      live_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      next_owner_r <= next_owner_nxt;
      live_r       <= live_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    size_r       <= size_nxt;
    tag_r        <= tag_nxt;
    res_status_r <= res_status_nxt;
    res_owner_r  <= res_owner_nxt;
    res_first_r  <= res_first_nxt;
    res_last_r   <= res_last_nxt;
    if ((state_r == S_RESP) && out_load) begin
      out_status_r <= res_status_r;
      out_owner_r  <= ffca_pkg::TAG_W'(res_owner_r);
      out_start_r  <= ffca_pkg::CELL_W'(res_first_r);
      out_end_r    <= ffca_pkg::CELL_W'(res_last_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_owner_out  = out_owner_r;
  assign out_start_cell = out_start_r;
  assign out_end_cell   = out_end_r;

endmodule
`default_nettype wire
